// ===== hdl/chacha_pkg.sv =====
package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int NUM_REGS          = 7;
  localparam int ADDR_W            = 6;

  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] matrix_t;

  // Queue entry handed from the front end to the keystream engine.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } item_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round on four words, returned as {a,b,c,d}.
  function automatic logic [127:0] qround(input word_t a, input word_t b,
                                          input word_t c, input word_t d);
    word_t ta, tb, tc, td;
    ta = a + b; td = rotl(d ^ ta, 16);
    tc = c + td; tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    qround = {ta, tb, tc, td};
  endfunction

endpackage

// ===== hdl/chacha_if.sv =====
interface chacha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface chacha_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== hdl/chacha_front.sv =====
// Two-entry queue between the input channel and the engine.
module chacha_front (
  input  logic                  clk,
  input  logic                  rst_n,
  chacha_in_if.sink             in_ch,
  output chacha_pkg::item_t     q_item,
  output logic                  q_valid,
  input  logic                  q_pop
);
  chacha_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_ch.data_byte, first: in_ch.first};
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== hdl/chacha_core.sv =====
// Keystream engine: one column round or diagonal round (four quarter rounds) per cycle.
module chacha_core #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  chacha_pkg::item_t  q_item,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [63:0]        key01,
  input  logic [63:0]        key23,
  input  logic [63:0]        key45,
  input  logic [63:0]        key67,
  input  logic [63:0]        nonce01,
  input  logic [31:0]        nonce2,
  input  logic [31:0]        start_cnt,
  chacha_out_if.source       out_ch
);
  localparam int HR   = 2 * DOUBLE_ROUNDS;
  localparam int HR_W = $clog2(HR);
  localparam logic [1:0] S_IDLE = 2'd0, S_ROUND = 2'd1, S_ADD = 2'd2;

  logic [1:0]          st_r, st_nxt;
  logic [HR_W-1:0]     rnd_r;
  chacha_pkg::matrix_t w_r, init_r, ks_r;
  logic [5:0]          pos_r;
  logic [31:0]         cnt_r;
  logic [7:0]          data_r;
  logic [7:0]          obyte_r;
  logic                ovalid_r;
  logic                out_free;
  logic                need_blk;
  logic [31:0]         ctr;
  chacha_pkg::matrix_t init_c, w_nxt;
  chacha_pkg::word_t   ksw;

  assign out_free = !ovalid_r || out_ch.ready;
  assign need_blk = q_item.first || (pos_r == 6'd0);
  assign ctr      = q_item.first ? start_cnt : cnt_r;
  assign q_pop    = ((st_r == S_IDLE) && q_valid && out_free && !need_blk) ||
                    ((st_r == S_ADD) && out_free);
  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_byte = obyte_r;
  assign ksw = ks_r[pos_r[5:2]];

  always_comb begin
    init_c[0] = chacha_pkg::SIGMA0; init_c[1] = chacha_pkg::SIGMA1;
    init_c[2] = chacha_pkg::SIGMA2; init_c[3] = chacha_pkg::SIGMA3;
    init_c[4] = key01[31:0]; init_c[5]  = key01[63:32];
    init_c[6] = key23[31:0]; init_c[7]  = key23[63:32];
    init_c[8] = key45[31:0]; init_c[9]  = key45[63:32];
    init_c[10] = key67[31:0]; init_c[11] = key67[63:32];
    init_c[12] = ctr;
    init_c[13] = nonce01[31:0]; init_c[14] = nonce01[63:32];
    init_c[15] = nonce2;
  end

  // Even steps mix columns, odd steps mix diagonals.
  always_comb begin
    w_nxt = w_r;
    if (!rnd_r[0]) begin
      {w_nxt[0], w_nxt[4], w_nxt[8],  w_nxt[12]} = chacha_pkg::qround(w_r[0], w_r[4], w_r[8], w_r[12]);
      {w_nxt[1], w_nxt[5], w_nxt[9],  w_nxt[13]} = chacha_pkg::qround(w_r[1], w_r[5], w_r[9], w_r[13]);
      {w_nxt[2], w_nxt[6], w_nxt[10], w_nxt[14]} = chacha_pkg::qround(w_r[2], w_r[6], w_r[10], w_r[14]);
      {w_nxt[3], w_nxt[7], w_nxt[11], w_nxt[15]} = chacha_pkg::qround(w_r[3], w_r[7], w_r[11], w_r[15]);
    end else begin
      {w_nxt[0], w_nxt[5], w_nxt[10], w_nxt[15]} = chacha_pkg::qround(w_r[0], w_r[5], w_r[10], w_r[15]);
      {w_nxt[1], w_nxt[6], w_nxt[11], w_nxt[12]} = chacha_pkg::qround(w_r[1], w_r[6], w_r[11], w_r[12]);
      {w_nxt[2], w_nxt[7], w_nxt[8],  w_nxt[13]} = chacha_pkg::qround(w_r[2], w_r[7], w_r[8], w_r[13]);
      {w_nxt[3], w_nxt[4], w_nxt[9],  w_nxt[14]} = chacha_pkg::qround(w_r[3], w_r[4], w_r[9], w_r[14]);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid && need_blk) st_nxt = S_ROUND;
      S_ROUND: if (rnd_r == HR_W'(HR - 1)) st_nxt = S_ADD;
      S_ADD:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rnd_r <= '0; pos_r <= 6'd0; cnt_r <= 32'd0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // Every queue pop emits one byte.
      if (q_pop) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid && need_blk) begin
            w_r    <= init_c;
            init_r <= init_c;
            cnt_r  <= ctr + 32'd1;
            data_r <= q_item.data;
            rnd_r  <= '0;
          end else if (q_pop) begin
            obyte_r  <= q_item.data ^ ksw[8*pos_r[1:0] +: 8];
            pos_r    <= pos_r + 6'd1;
          end
        end
        S_ROUND: begin
          w_r   <= w_nxt;
          rnd_r <= rnd_r + HR_W'(1);
          if (rnd_r == HR_W'(HR - 1)) begin
            for (int i = 0; i < 16; i++) ks_r[i] <= w_nxt[i] + init_r[i];
          end
        end
        S_ADD: begin
          // Emit byte 0 of the fresh block and retire the queue entry.
          if (out_free) begin
            obyte_r  <= data_r ^ ks_r[0][7:0];
            pos_r    <= 6'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/chacha20_stream_cipher_top.sv =====
// The iterative round unit computes one column or diagonal round per cycle when a block
// starts; inside a block one byte per cycle is emitted while the output channel accepts.
// Reset (rst_n, synchronous): registers to defaults, counter and position to zero.
// Keystream contents are undefined until the first block is computed.
module chacha20_stream_cipher_top #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  chacha_in_if.sink                     in_ch,
  chacha_out_if.source                  out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [chacha_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [63:0]                   cfg_pwdata,
  output logic [63:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0] nonce2_r, start_r;
  logic [2:0]  ridx;
  logic        wr, q_valid, q_pop;
  chacha_pkg::item_t q_item;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[5:3];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= '0; key23_r <= '0; key45_r <= '0; key67_r <= 64'h1_0000_0000;
      nonce01_r <= '0; nonce2_r <= 32'd2; start_r <= '0;
    end else if (wr) begin
      unique case (ridx)
        chacha_pkg::REG_KEY01:   key01_r   <= cfg_pwdata;
        chacha_pkg::REG_KEY23:   key23_r   <= cfg_pwdata;
        chacha_pkg::REG_KEY45:   key45_r   <= cfg_pwdata;
        chacha_pkg::REG_KEY67:   key67_r   <= cfg_pwdata;
        chacha_pkg::REG_NONCE01: nonce01_r <= cfg_pwdata;
        chacha_pkg::REG_NONCE2:  nonce2_r  <= cfg_pwdata[31:0];
        chacha_pkg::REG_START:   start_r   <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      chacha_pkg::REG_KEY01:   cfg_prdata = key01_r;
      chacha_pkg::REG_KEY23:   cfg_prdata = key23_r;
      chacha_pkg::REG_KEY45:   cfg_prdata = key45_r;
      chacha_pkg::REG_KEY67:   cfg_prdata = key67_r;
      chacha_pkg::REG_NONCE01: cfg_prdata = nonce01_r;
      chacha_pkg::REG_NONCE2:  cfg_prdata = {32'd0, nonce2_r};
      chacha_pkg::REG_START:   cfg_prdata = {32'd0, start_r};
      default:                 cfg_prdata = 64'd0;
    endcase
  end

  chacha_front u_front (
    .clk, .rst_n, .in_ch, .q_item, .q_valid, .q_pop
  );

  chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk, .rst_n, .q_item, .q_valid, .q_pop,
    .key01(key01_r), .key23(key23_r), .key45(key45_r), .key67(key67_r),
    .nonce01(nonce01_r), .nonce2(nonce2_r), .start_cnt(start_r), .out_ch
  );
endmodule
